// ----- hdl/epws_pkg.sv -----
package epws_pkg;

  // Page size in bytes; page boundaries are found by masking, so keep it a power of two.
  localparam int PAGE_BYTES = 16;
  localparam int PAGE_BITS  = $clog2(PAGE_BYTES);

  localparam int ADDR_W   = 16;
  localparam int COUNT_W  = 16;
  localparam int LEN_W    = 8;
  localparam int BASE_W   = 7;
  localparam int STATUS_W = 2;

  localparam logic [BASE_W-1:0] DEVICE_BASE_RESET = 7'd80;

  localparam logic FUNC_NEW  = 1'b0;
  localparam logic FUNC_CONT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_PEND = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BUSY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DONE = 2'd2;

  typedef struct packed {
    logic               func;
    logic [ADDR_W-1:0]  start_addr;
    logic [ADDR_W-1:0]  source_addr;
    logic [COUNT_W-1:0] byte_count;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [7:0]          select_byte;
    logic [7:0]          addr_low;
    logic [LEN_W-1:0]    chunk_len;
    logic [ADDR_W-1:0]   data_addr;
  } out_item_t;

endpackage

// ----- hdl/eeprom_page_write_splitter.sv -----
// Splits EEPROM write requests into chunk descriptors that never cross a page.
// Input channel (in_valid/in_stall/in_data): func 0 is a new request with
// start address, source address and byte count; func 1 asks for the next chunk.
// Output channel (out_valid/out_stall/out_data): one descriptor per input
// transaction with status pending, busy (new request while one is outstanding)
// or complete (continuation with nothing left).
// Configuration: cfg_wr_en writes cfg_wr_data into the device base register;
// write it only while no transaction is in flight.
// Path: a transaction taken on the input goes into the input register, then its
// result into the result register. Throughput: one transaction per cycle
// while out_stall is low; the combinational chunk computation between the two
// registers sets this rate.
// Reset (rst, synchronous): both channels go empty, nothing is outstanding and
// the device base returns to 80.
// When out_stall is high the result holds; one more input transaction is
// taken into the input register, after which in_stall rises until the
// result register drains.
module eeprom_page_write_splitter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [epws_pkg::BASE_W-1:0] cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  epws_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output epws_pkg::out_item_t         out_data
);

  logic                advance;
  logic                item_valid;
  epws_pkg::in_item_t  item;
  epws_pkg::out_item_t result;

  epws_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  epws_chunk u_chunk (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (item_valid && advance),
    .item        (item),
    .result      (result)
  );

  epws_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .result     (result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

`ifndef SYNTHESIS
  // A pending chunk stays inside one page.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status == epws_pkg::ST_PEND |->
      (9'(out_data.addr_low[epws_pkg::PAGE_BITS-1:0]) + 9'(out_data.chunk_len))
        <= 9'(epws_pkg::PAGE_BYTES))
    else $error("chunk crosses a page boundary");

  // Busy and complete answers carry no chunk.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != epws_pkg::ST_PEND |->
      out_data.chunk_len == '0 && out_data.select_byte == '0 &&
      out_data.addr_low == '0 && out_data.data_addr == '0)
    else $error("non-pending result carries chunk fields");

  // The input register never drops an item while the output side is stalled.
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !advance |=> item_valid && $stable(item))
    else $error("held item lost under stall");
`endif

endmodule

// ----- hdl/epws_in_stage.sv -----
module epws_in_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  epws_pkg::in_item_t in_data,
  input  logic              advance,
  output logic              item_valid,
  output epws_pkg::in_item_t item
);

  // Hold the registered item while the result stage cannot take it.
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_data;
    end
  end

endmodule

// ----- hdl/epws_chunk.sv -----
module epws_chunk (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [epws_pkg::BASE_W-1:0]       cfg_wr_data,
  input  logic                              fire,
  input  epws_pkg::in_item_t                item,
  output epws_pkg::out_item_t               result
);

  logic [epws_pkg::BASE_W-1:0]  device_base;
  logic [epws_pkg::COUNT_W-1:0] remaining_count;
  logic [epws_pkg::ADDR_W-1:0]  next_eeprom_addr;
  logic [epws_pkg::ADDR_W-1:0]  next_data_addr;

  logic [epws_pkg::COUNT_W-1:0] remaining_count_next;
  logic [epws_pkg::ADDR_W-1:0]  next_eeprom_addr_next;
  logic [epws_pkg::ADDR_W-1:0]  next_data_addr_next;

  logic                         idle;
  logic                         issue;
  logic [epws_pkg::COUNT_W-1:0] cur_count;
  logic [epws_pkg::ADDR_W-1:0]  cur_eeprom;
  logic [epws_pkg::ADDR_W-1:0]  cur_data;
  logic [epws_pkg::LEN_W-1:0]   to_page_end;
  logic [epws_pkg::LEN_W-1:0]   len;

  always_comb begin
    idle       = (remaining_count == '0);
    // A new request starts from its own fields; a continuation from the saved pointers.
    cur_count  = idle ? item.byte_count  : remaining_count;
    cur_eeprom = idle ? item.start_addr  : next_eeprom_addr;
    cur_data   = idle ? item.source_addr : next_data_addr;

    // Bytes up to the end of the page; a whole page when the address is aligned.
    to_page_end = epws_pkg::LEN_W'(epws_pkg::PAGE_BYTES)
                - epws_pkg::LEN_W'(cur_eeprom[epws_pkg::PAGE_BITS-1:0]);
    len = (epws_pkg::COUNT_W'(to_page_end) > cur_count)
        ? cur_count[epws_pkg::LEN_W-1:0] : to_page_end;

    issue = (idle && item.func == epws_pkg::FUNC_NEW)
         || (!idle && item.func == epws_pkg::FUNC_CONT);

    result = '0;
    if (issue) begin
      result.status      = epws_pkg::ST_PEND;
      result.select_byte = {device_base | cur_eeprom[14:8], 1'b0};
      result.addr_low    = cur_eeprom[7:0];
      result.chunk_len   = len;
      result.data_addr   = cur_data;
    end else if (idle) begin
      result.status = epws_pkg::ST_DONE;
    end else begin
      result.status = epws_pkg::ST_BUSY;
    end

    remaining_count_next  = cur_count  - epws_pkg::COUNT_W'(len);
    next_eeprom_addr_next = cur_eeprom + epws_pkg::ADDR_W'(len);
    next_data_addr_next   = cur_data   + epws_pkg::ADDR_W'(len);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      device_base      <= epws_pkg::DEVICE_BASE_RESET;
      remaining_count  <= '0;
      next_eeprom_addr <= '0;
      next_data_addr   <= '0;
    end else begin
      if (cfg_wr_en) begin
        device_base <= cfg_wr_data;
      end
      if (fire && issue) begin
        remaining_count  <= remaining_count_next;
        next_eeprom_addr <= next_eeprom_addr_next;
        next_data_addr   <= next_data_addr_next;
      end
    end
  end

endmodule

// ----- hdl/epws_out_stage.sv -----
module epws_out_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  epws_pkg::out_item_t result,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_stall,
  output epws_pkg::out_item_t out_data
);

  // Load a new result when the register is empty or its transaction completes now.
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      out_data <= result;
    end
  end

endmodule
